@@ rtl/gast_pkg.sv @@
// gast_pkg: command codes, status codes and sequencer states for the
// group access set table. No dependencies.
package gast_pkg;

  // command codes
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_PURGE  = 2'd2;
  localparam logic [1:0] CMD_CHECK  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOMEM  = 2'd1;
  localparam logic [1:0] ST_DENIED = 2'd2;

  // stored pair layout: {fabric[23:16], group[15:0]}
  localparam int PAIR_W = 24;

  typedef logic [PAIR_W-1:0] pair_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EVAL = 3'b100
  } state_t;

endpackage

@@ rtl/group_access_set_table.sv @@
// group_access_set_table: compact list of (fabric, group) pairs with add,
// remove, purge-fabric and check-access commands.
// Depends on gast_pkg.
//
// Usage: drive cmd and its operands with start high while busy is low; the
// request is taken at that clock edge. One result (status, entry_count) is
// shown for exactly one cycle with done high; the receiver cannot stall it.
// busy is low again in the done cycle, so the next request may be taken there.
// Each request is a single memory walk with two steps per stored pair: S_READ
// for the registered read of the pair memory, S_EVAL for compare and
// compaction write; a final S_READ step finishes and registers the result.
// Add when full, or check without group auth/invoke/operate, is answered
// from S_IDLE with no walk. Add and check stop at the matching pair, else
// walk the whole list; remove and purge always walk the whole list.
// The single-port pair memory sets the rate; a new request is taken only
// once the last one is done.
// Reset clears the pair count and the sequencer; pair memory contents are
// not cleared, since only entries below the count are ever read.
module group_access_set_table
  import gast_pkg::*;
#(
  parameter int MAX_PAIRS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [7:0]  fabric,
  input  logic [15:0] group_id,
  input  logic [63:0] subject,
  input  logic        is_group_auth,
  input  logic        is_invoke,
  input  logic        is_operate,
  output logic        done,
  output logic [1:0]  status,
  output logic [4:0]  entry_count
);

  localparam int CW = $clog2(MAX_PAIRS + 1);
  localparam int AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PAIRS);

  state_t        state;
  logic [1:0]    op;
  pair_t         key;
  logic [CW-1:0] cnt;
  logic [CW-1:0] rd_idx;
  logic [CW-1:0] wr_idx;
  logic          dropped;
  pair_t         rd_data;

  pair_t         mem [MAX_PAIRS];

  // memory write request from the sequencer
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  pair_t         mem_wdata;

  // compare and compaction decisions on the pair just read
  logic hit;
  logic fab_hit;
  logic drop;

  assign hit     = (rd_data == key);
  assign fab_hit = (rd_data[PAIR_W-1:16] == key[PAIR_W-1:16]);

  always_comb begin
    drop = 1'b0;
    case (op)
      CMD_REMOVE: drop = hit && !dropped;
      CMD_PURGE:  drop = fab_hit;
      default:    drop = 1'b0;
    endcase
  end

  // write port: append on add, shift down on remove and purge
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_idx[AW-1:0];
    mem_wdata = rd_data;
    if (state == S_READ && rd_idx == cnt && op == CMD_ADD) begin
      mem_we    = 1'b1;
      mem_waddr = cnt[AW-1:0];
      mem_wdata = key;
    end else if (state == S_EVAL && (op == CMD_REMOVE || op == CMD_PURGE) && !drop) begin
      mem_we = 1'b1;
    end
  end

  // pair memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state == S_READ && rd_idx != cnt) begin
      rd_data <= mem[rd_idx[AW-1:0]];
    end
  end

  assign busy = (state != S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op       <= cmd;
            rd_idx   <= '0;
            wr_idx   <= '0;
            dropped  <= 1'b0;
            if (cmd == CMD_CHECK) begin
              key <= {fabric, subject[15:0]};
            end else begin
              key <= {fabric, group_id};
            end
            if (cmd == CMD_ADD && cnt >= MAX_CNT) begin
              done   <= 1'b1;
              status <= ST_NOMEM;
            end else if (cmd == CMD_CHECK &&
                         !(is_group_auth && is_invoke && is_operate)) begin
              done   <= 1'b1;
              status <= ST_DENIED;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          if (rd_idx == cnt) begin
            // end of list reached
            state <= S_IDLE;
            done  <= 1'b1;
            case (op)
              CMD_ADD: begin
                status <= ST_OK;
                cnt    <= cnt + 1'b1;
              end
              CMD_CHECK: begin
                status <= ST_DENIED;
              end
              default: begin
                status <= ST_OK;
                cnt    <= wr_idx;
              end
            endcase
          end else begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if ((op == CMD_ADD || op == CMD_CHECK) && hit) begin
            // pair already listed: add changes nothing, check grants
            state  <= S_IDLE;
            done   <= 1'b1;
            status <= ST_OK;
          end else begin
            state  <= S_READ;
            rd_idx <= rd_idx + 1'b1;
            if (mem_we) begin
              wr_idx <= wr_idx + 1'b1;
            end
            if (drop) begin
              dropped <= 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign entry_count = 5'(cnt);

endmodule

@@ rtl/gast_checker.sv @@
// gast_props: port-level checks on the group access set table handshake
// and results; bound to group_access_set_table. Depends on gast_pkg.
module gast_props
  import gast_pkg::*;
#(
  parameter int MAX_PAIRS = 16
) (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [1:0] status,
  input logic [4:0] entry_count
);

  // a taken request is either still at work or answered next cycle
  a_taken_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done)
    else $error("request taken but block neither busy nor done");

  // a result never overlaps work on a request
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // no memory only when the list is full
  a_nomem_full: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_NOMEM |-> entry_count == 5'(MAX_PAIRS))
    else $error("no memory reported with room left");

  // status is always a defined code
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> status == ST_OK || status == ST_NOMEM || status == ST_DENIED)
    else $error("undefined status code");

endmodule

bind group_access_set_table gast_props #(.MAX_PAIRS(MAX_PAIRS)) u_gast_props (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .status      (status),
  .entry_count (entry_count)
);
